// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the tokenizer modules.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define STOK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define STOK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/stok_pkg.sv -----
package stok_pkg;

  // Default counter widths.
  localparam int POSITION_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF   = 8;

  // Widths of the result fields on the ports.
  localparam int OUT_POS_W = 16;
  localparam int OUT_LEN_W = 8;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Characters with a special meaning to the lexer.
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_RPAREN  = 8'h29;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
  localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  // Lexer modes.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_INT     = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_COMMENT = 3'd5,
    MODE_HALT    = 3'd6
  } mode_e;

  // Result kinds.
  typedef enum logic [3:0] {
    KIND_CHAR   = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_INT    = 4'd2,
    KIND_STRING = 4'd3,
    KIND_LPAREN = 4'd4,
    KIND_RPAREN = 4'd5,
    KIND_LBRACE = 4'd6,
    KIND_RBRACE = 4'd7,
    KIND_PLUS   = 4'd8,
    KIND_MINUS  = 4'd9,
    KIND_STAR   = 4'd10,
    KIND_SLASH  = 4'd11,
    KIND_ASSIGN = 4'd12,
    KIND_SEMI   = 4'd13,
    KIND_EOF    = 4'd14,
    KIND_ERROR  = 4'd15
  } kind_e;

  // One result beat as it leaves the block.
  typedef struct packed {
    kind_e                kind;
    logic [7:0]           value_char;
    logic [OUT_POS_W-1:0] start_line;
    logic [OUT_POS_W-1:0] start_column;
    logic [OUT_LEN_W-1:0] value_length;
    logic                 last;
  } result_t;

  // Results produced by one accepted byte, in order: r0 first.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // Kind of a single-character operator; KIND_ERROR for anything else.
  function automatic kind_e op_kind(logic [7:0] c);
    kind_e k;
    case (c)
      CHAR_LPAREN: k = KIND_LPAREN;
      CHAR_RPAREN: k = KIND_RPAREN;
      CHAR_LBRACE: k = KIND_LBRACE;
      CHAR_RBRACE: k = KIND_RBRACE;
      CHAR_PLUS:   k = KIND_PLUS;
      CHAR_MINUS:  k = KIND_MINUS;
      CHAR_STAR:   k = KIND_STAR;
      CHAR_EQUAL:  k = KIND_ASSIGN;
      CHAR_SEMI:   k = KIND_SEMI;
      default:     k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/source_tokenizer_core.sv -----
// Streaming source tokenizer.
// Input channel: one source byte per beat on source_byte_i (in_valid_i / in_ready_o);
// byte 0 marks end of input. Output channel: one result per beat (out_valid_o /
// out_ready_i) with kind, value character, start line and column, value length and
// a last flag on the final result caused by an input byte.
// A byte is lexed in the cycle it is accepted; its results are registered in a
// four-entry result queue and reach the output from there, oldest first.
// Throughput is one byte per cycle while the queue has room. A byte gives zero,
// one or two results; bytes that give two (a token closed by the next token's
// first character) drain at one result per cycle while the receiver is ready,
// so a long run of them is limited by the single output port of the queue.
// in_ready_o is high while the queue has room for two results, so a stalled receiver
// holds back the input only once fewer than two entries are free; nothing is dropped.
// Reset clears the lexer to idle, the line, column and token counters to zero and
// empties the queue. An unknown character or an unterminated string gives an error
// result, after which bytes are still taken but give nothing until reset.
module source_tokenizer_core import stok_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           source_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           kind_o,
  output logic [7:0]           value_char_o,
  output logic [OUT_POS_W-1:0] start_line_o,
  output logic [OUT_POS_W-1:0] start_column_o,
  output logic [OUT_LEN_W-1:0] value_length_o,
  output logic                 last_o
);

  logic    accept;
  push_t   push;
  result_t head;

  assign accept = in_valid_i & in_ready_o;

  // Mode machine and counters.
  stok_lexer #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_lexer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .source_byte_i(source_byte_i),
    .push_o       (push)
  );

  // Result queue between the lexer and the receiver.
  stok_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head)
  );

  assign kind_o         = head.kind;
  assign value_char_o   = head.value_char;
  assign start_line_o   = head.start_line;
  assign start_column_o = head.start_column;
  assign value_length_o = head.value_length;
  assign last_o         = head.last;

endmodule

// ----- rtl/stok_lexer.sv -----
`include "assert_macros.svh"

module stok_lexer import stok_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] source_byte_i,
  output push_t      push_o
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [LENGTH_BITS-1:0]   LenMax = '1;

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d;
  logic [POSITION_BITS-1:0] col_q, col_d;
  logic [POSITION_BITS-1:0] tok_line_q, tok_line_d;
  logic [POSITION_BITS-1:0] tok_col_q, tok_col_d;
  logic [LENGTH_BITS-1:0]   tok_len_q, tok_len_d;

  logic [LENGTH_BITS-1:0] len_inc;
  logic                   cont;
  logic                   idle_path;
  logic                   pre_v, idle_v;
  result_t                pre_r, idle_r;
  kind_e                  op_k;
  logic [1:0]             n_res;

  // Saturate an internal position to the port width.
  function automatic logic [OUT_POS_W-1:0] clamp_pos(logic [POSITION_BITS-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return (ext > 32'({OUT_POS_W{1'b1}})) ? {OUT_POS_W{1'b1}} : ext[OUT_POS_W-1:0];
  endfunction

  // Saturate an internal length to the port width.
  function automatic logic [OUT_LEN_W-1:0] clamp_len(logic [LENGTH_BITS-1:0] v);
    logic [15:0] ext;
    ext = 16'(v);
    return (ext > 16'({OUT_LEN_W{1'b1}})) ? {OUT_LEN_W{1'b1}} : ext[OUT_LEN_W-1:0];
  endfunction

  function automatic result_t mk(kind_e k, logic [7:0] ch, logic [POSITION_BITS-1:0] ln,
                                 logic [POSITION_BITS-1:0] cl, logic [LENGTH_BITS-1:0] len);
    result_t r;
    r.kind         = k;
    r.value_char   = ch;
    r.start_line   = clamp_pos(ln);
    r.start_column = clamp_pos(cl);
    r.value_length = clamp_len(len);
    r.last         = 1'b0;
    return r;
  endfunction

  assign len_inc = (tok_len_q == LenMax) ? tok_len_q : tok_len_q + LENGTH_BITS'(1);
  assign op_k    = op_kind(source_byte_i);
  assign cont    = (mode_q == MODE_IDENT) ? is_alpha(source_byte_i) : is_digit(source_byte_i);

  // Next state and results for the byte at the input.
  always_comb begin
    mode_d     = mode_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_len_d  = tok_len_q;
    line_d     = line_q;
    col_d      = col_q;
    pre_v      = 1'b0;
    pre_r      = '0;
    idle_v     = 1'b0;
    idle_r     = '0;
    idle_path  = 1'b0;

    // First the mode that was open before this byte.
    case (mode_q)
      MODE_IDENT, MODE_INT: begin
        pre_v = 1'b1;
        if (cont) begin
          tok_len_d = len_inc;
          pre_r     = mk(KIND_CHAR, source_byte_i, tok_line_q, tok_col_q, len_inc);
        end else begin
          pre_r     = mk((mode_q == MODE_IDENT) ? KIND_IDENT : KIND_INT, 8'h00,
                         tok_line_q, tok_col_q, tok_len_q);
          idle_path = 1'b1;
        end
      end
      MODE_STRING: begin
        pre_v = 1'b1;
        if (source_byte_i == CHAR_QUOTE) begin
          pre_r  = mk(KIND_STRING, 8'h00, tok_line_q, tok_col_q, tok_len_q);
          mode_d = MODE_IDLE;
        end else if (source_byte_i == CHAR_NUL) begin
          pre_r  = mk(KIND_ERROR, 8'h00, tok_line_q, tok_col_q, '0);
          mode_d = MODE_HALT;
        end else begin
          tok_len_d = len_inc;
          pre_r     = mk(KIND_CHAR, source_byte_i, tok_line_q, tok_col_q, len_inc);
        end
      end
      MODE_SLASH: begin
        if (source_byte_i == CHAR_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          pre_v     = 1'b1;
          pre_r     = mk(KIND_SLASH, 8'h00, tok_line_q, tok_col_q, '0);
          idle_path = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (source_byte_i == CHAR_NEWLINE) begin
          mode_d = MODE_IDLE;
        end else if (source_byte_i == CHAR_NUL) begin
          idle_path = 1'b1;
        end
      end
      MODE_IDLE: begin
        idle_path = 1'b1;
      end
      default: begin
      end
    endcase

    // Then the byte lexed from idle, when the open token did not take it.
    if (idle_path) begin
      mode_d = MODE_IDLE;
      if (source_byte_i == CHAR_NUL) begin
        idle_v = 1'b1;
        idle_r = mk(KIND_EOF, 8'h00, line_q, col_q, '0);
      end else if (is_space(source_byte_i)) begin
        mode_d = MODE_IDLE;
      end else if (is_alpha(source_byte_i) || is_digit(source_byte_i)) begin
        mode_d     = is_alpha(source_byte_i) ? MODE_IDENT : MODE_INT;
        tok_line_d = line_q;
        tok_col_d  = col_q;
        tok_len_d  = LENGTH_BITS'(1);
        idle_v     = 1'b1;
        idle_r     = mk(KIND_CHAR, source_byte_i, line_q, col_q, LENGTH_BITS'(1));
      end else if (source_byte_i == CHAR_QUOTE || source_byte_i == CHAR_SLASH) begin
        mode_d     = (source_byte_i == CHAR_QUOTE) ? MODE_STRING : MODE_SLASH;
        tok_line_d = line_q;
        tok_col_d  = col_q;
        tok_len_d  = '0;
      end else begin
        // Operators, or an unknown character that stops the lexer.
        idle_v = 1'b1;
        idle_r = mk(op_k, 8'h00, line_q, col_q, '0);
        if (op_k == KIND_ERROR) begin
          mode_d = MODE_HALT;
        end
      end
    end

    // Advance the position of the next byte.
    if (source_byte_i != CHAR_NUL && mode_d != MODE_HALT) begin
      if (source_byte_i == CHAR_NEWLINE) begin
        line_d = (line_q == PosMax) ? line_q : line_q + POSITION_BITS'(1);
        col_d  = '0;
      end else begin
        col_d = (col_q == PosMax) ? col_q : col_q + POSITION_BITS'(1);
      end
    end
  end

  // Pack up to two results per beat and flag the final one.
  always_comb begin
    n_res  = accept_i ? (2'(pre_v) + 2'(idle_v)) : 2'd0;
    push_o = '0;
    push_o.count = n_res;
    push_o.r0    = pre_v ? pre_r : idle_r;
    push_o.r1    = idle_r;
    if (n_res == 2'd2) begin
      push_o.r1.last = 1'b1;
    end else begin
      push_o.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      line_q     <= '0;
      col_q      <= '0;
      tok_line_q <= '0;
      tok_col_q  <= '0;
      tok_len_q  <= '0;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
    end
  end

  `STOK_ASSERT_NEXT(a_halt_sticky, mode_q == MODE_HALT, mode_q == MODE_HALT,
                    "lexer left the halted mode")
  `STOK_ASSERT(a_two_results_last,
               (push_o.count != 2'd2) || (!push_o.r0.last && push_o.r1.last),
               "last flag not on the second of two results")

endmodule

// ----- rtl/stok_fifo.sv -----
`include "assert_macros.svh"

module stok_fifo import stok_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t head_o
);

  result_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [CNT_W-1:0]   count_q;
  logic               pop;

  // Room for the worst case of two results from the next beat.
  assign room_o      = count_q <= CNT_W'(FIFO_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  assign wr_ptr_nxt  = wr_ptr_q + PTR_W'(1);

  // Result storage, no reset needed on the payload.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.r1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_q + CNT_W'(push_i.count) - CNT_W'(pop);
    end
  end

  `STOK_ASSERT(a_no_overflow, count_q <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `STOK_ASSERT(a_push_has_room,
               (push_i.count == 2'd0) || (count_q <= CNT_W'(FIFO_DEPTH - 2)),
               "results pushed without room for two")
  `STOK_ASSERT(a_ptr_match, (wr_ptr_q - rd_ptr_q) == count_q[PTR_W-1:0],
               "queue pointers disagree with the fill level")

endmodule

// ----- dv/token_checker.sv -----
`timescale 1ns / 100ps

// Watches the byte and result channels of the tokenizer. Every accepted source
// byte is lexed by a local copy of the lexer, and the result beats it must cause
// are queued. Every accepted result beat is compared against the oldest entry.
module token_checker import stok_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           source_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [3:0]           kind_i,
  input  logic [7:0]           value_char_i,
  input  logic [OUT_POS_W-1:0] start_line_i,
  input  logic [OUT_POS_W-1:0] start_column_i,
  input  logic [OUT_LEN_W-1:0] value_length_i,
  input  logic                 last_i,
  output int                   failures_o,
  output int                   pending_o
);

  localparam logic [OUT_POS_W-1:0] POS_TOP = '1;
  localparam logic [OUT_LEN_W-1:0] LEN_TOP = '1;

  // Local lexer state: mode, position of the next byte, and the open token.
  mode_e                lexer_mode;
  logic [OUT_POS_W-1:0] pos_line;
  logic [OUT_POS_W-1:0] pos_column;
  logic [OUT_POS_W-1:0] tok_line;
  logic [OUT_POS_W-1:0] tok_column;
  logic [OUT_LEN_W-1:0] tok_length;

  // Result beats still owed by the block, oldest first.
  result_t owed_results[$];

  function automatic logic letter_p(logic [7:0] c);
    return (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A;
  endfunction

  function automatic logic digit_p(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic blank_p(logic [7:0] c);
    return c == CHAR_SPACE || c inside {[CHAR_TAB:CHAR_CR]};
  endfunction

  function automatic void owe_result(kind_e k, logic [7:0] ch, logic [OUT_POS_W-1:0] ln,
                                     logic [OUT_POS_W-1:0] col, logic [OUT_LEN_W-1:0] len);
    result_t r;
    r.kind         = k;
    r.value_char   = ch;
    r.start_line   = ln;
    r.start_column = col;
    r.value_length = len;
    r.last         = 1'b0;
    owed_results.insert(owed_results.size(), r);
  endfunction

  function automatic void open_token(mode_e m, logic [OUT_POS_W-1:0] ln,
                                     logic [OUT_POS_W-1:0] col);
    lexer_mode = m;
    tok_line   = ln;
    tok_column = col;
    tok_length = '0;
  endfunction

  // A character of an identifier, integer or string is reported at once.
  function automatic void owe_value_char(logic [7:0] c);
    if (tok_length != LEN_TOP) tok_length++;
    owe_result(KIND_CHAR, c, tok_line, tok_column, tok_length);
  endfunction

  // Lexes a byte as if no token were open.
  function automatic void lex_from_idle(logic [7:0] c, logic [OUT_POS_W-1:0] ln,
                                        logic [OUT_POS_W-1:0] col);
    lexer_mode = MODE_IDLE;
    if (c == CHAR_NUL) begin
      owe_result(KIND_EOF, 8'h00, ln, col, '0);
    end else if (letter_p(c) || digit_p(c)) begin
      open_token(letter_p(c) ? MODE_IDENT : MODE_INT, ln, col);
      owe_value_char(c);
    end else if (!blank_p(c)) begin
      case (c)
        CHAR_QUOTE:  open_token(MODE_STRING, ln, col);
        CHAR_SLASH:  open_token(MODE_SLASH, ln, col);
        CHAR_LPAREN: owe_result(KIND_LPAREN, 8'h00, ln, col, '0);
        CHAR_RPAREN: owe_result(KIND_RPAREN, 8'h00, ln, col, '0);
        CHAR_LBRACE: owe_result(KIND_LBRACE, 8'h00, ln, col, '0);
        CHAR_RBRACE: owe_result(KIND_RBRACE, 8'h00, ln, col, '0);
        CHAR_PLUS:   owe_result(KIND_PLUS, 8'h00, ln, col, '0);
        CHAR_MINUS:  owe_result(KIND_MINUS, 8'h00, ln, col, '0);
        CHAR_STAR:   owe_result(KIND_STAR, 8'h00, ln, col, '0);
        CHAR_EQUAL:  owe_result(KIND_ASSIGN, 8'h00, ln, col, '0);
        CHAR_SEMI:   owe_result(KIND_SEMI, 8'h00, ln, col, '0);
        default: begin
          owe_result(KIND_ERROR, 8'h00, ln, col, '0);
          lexer_mode = MODE_HALT;
        end
      endcase
    end
  endfunction

  // Works out every result beat of one accepted byte and advances the position.
  function automatic void lex_byte(logic [7:0] c);
    logic [OUT_POS_W-1:0] ln;
    logic [OUT_POS_W-1:0] col;
    int                   first;
    ln    = pos_line;
    col   = pos_column;
    first = owed_results.size();
    if (lexer_mode != MODE_HALT) begin
      case (lexer_mode)
        MODE_IDENT, MODE_INT: begin
          if (lexer_mode == MODE_IDENT ? letter_p(c) : digit_p(c)) begin
            owe_value_char(c);
          end else begin
            owe_result(lexer_mode == MODE_IDENT ? KIND_IDENT : KIND_INT, 8'h00,
                       tok_line, tok_column, tok_length);
            lex_from_idle(c, ln, col);
          end
        end
        MODE_STRING: begin
          if (c == CHAR_QUOTE) begin
            owe_result(KIND_STRING, 8'h00, tok_line, tok_column, tok_length);
            lexer_mode = MODE_IDLE;
          end else if (c == CHAR_NUL) begin
            // A string cut off by end of input is an error at its opening quote.
            owe_result(KIND_ERROR, 8'h00, tok_line, tok_column, '0);
            lexer_mode = MODE_HALT;
          end else begin
            owe_value_char(c);
          end
        end
        MODE_SLASH: begin
          if (c == CHAR_SLASH) begin
            lexer_mode = MODE_COMMENT;
          end else begin
            owe_result(KIND_SLASH, 8'h00, tok_line, tok_column, '0);
            lex_from_idle(c, ln, col);
          end
        end
        MODE_COMMENT: begin
          if (c == CHAR_NEWLINE) lexer_mode = MODE_IDLE;
          else if (c == CHAR_NUL) lex_from_idle(c, ln, col);
        end
        default: lex_from_idle(c, ln, col);
      endcase

      // Nonzero bytes move the position; both counters stick at their top.
      if (c != CHAR_NUL && lexer_mode != MODE_HALT) begin
        if (c == CHAR_NEWLINE) begin
          if (pos_line != POS_TOP) pos_line++;
          pos_column = '0;
        end else if (pos_column != POS_TOP) begin
          pos_column++;
        end
      end

      if (owed_results.size() > first) owed_results[owed_results.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures_o++;
    end
  endfunction

  // Predict on each accepted byte first, so that the queue already holds
  // everything a result beat at the same edge could belong to.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      lexer_mode = MODE_IDLE;
      pos_line   = '0;
      pos_column = '0;
      tok_line   = '0;
      tok_column = '0;
      tok_length = '0;
      owed_results.delete();
      failures_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) lex_byte(source_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("result beat with none expected: kind %0d", kind_i);
          failures_o++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(kind_i));
          check_field("value_char", 16'(want.value_char), 16'(value_char_i));
          check_field("start_line", 16'(want.start_line), 16'(start_line_i));
          check_field("start_column", 16'(want.start_column), 16'(start_column_i));
          check_field("value_length", 16'(want.value_length), 16'(value_length_i));
          check_field("last", 16'(want.last), 16'(last_i));
        end
      end
    end
    pending_o = owed_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import stok_pkg::*;

  localparam logic [7:0] CHAR_VTAB  = 8'h0B;
  localparam logic [7:0] CHAR_FFEED = 8'h0C;
  localparam int RANDOM_BYTES = 130;
  localparam int GAP_PERCENT  = 21;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic [7:0]           source_byte_i = 8'h00;
  logic                 out_ready_i = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [3:0]           kind_o;
  logic [7:0]           value_char_o;
  logic [OUT_POS_W-1:0] start_line_o;
  logic [OUT_POS_W-1:0] start_column_o;
  logic [OUT_LEN_W-1:0] value_length_o;
  logic                 last_o;

  int failures;
  int pending;
  int sent;
  // While set, neither side inserts idle cycles.
  bit steady = 1'b0;

  logic [7:0] op_chars[10] = '{CHAR_LPAREN, CHAR_RPAREN, CHAR_LBRACE, CHAR_RBRACE,
                               CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH,
                               CHAR_EQUAL, CHAR_SEMI};
  logic [7:0] blank_chars[6] = '{CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_VTAB,
                                 CHAR_FFEED, CHAR_CR};
  logic [7:0] stray_chars[4] = '{8'h21, 8'h23, 8'h40, 8'h7E};

  always #5 clk_i = ~clk_i;

  source_tokenizer_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .source_byte_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .value_char_o,
    .start_line_o,
    .start_column_o,
    .value_length_o,
    .last_o
  );

  token_checker lex_check (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .source_byte_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .kind_i         (kind_o),
    .value_char_i   (value_char_o),
    .start_line_i   (start_line_o),
    .start_column_i (start_column_o),
    .value_length_i (value_length_o),
    .last_i         (last_o),
    .failures_o     (failures),
    .pending_o      (pending)
  );

  // The receiver stalls at random unless the steady stretch is on.
  always @(negedge clk_i) begin
    out_ready_i = steady || ($urandom_range(99) >= GAP_PERCENT);
  end

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
  endfunction

  // Any nonzero byte except the one that would end the current construct.
  function automatic logic [7:0] rand_other(logic [7:0] banned);
    logic [7:0] b;
    do b = 8'($urandom_range(255, 1)); while (b == banned);
    return b;
  endfunction

  // Presents one beat from a falling edge and holds it until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < GAP_PERCENT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    source_byte_i = b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // One random lexical piece; pieces run together, so tokens often end on the
  // first character of the next one.
  task automatic send_piece();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 22) begin
      n = $urandom_range(8, 1);
      repeat (n) send_byte(rand_letter());
    end else if (pick < 38) begin
      n = $urandom_range(6, 1);
      repeat (n) send_byte(8'h30 + 8'($urandom_range(9)));
    end else if (pick < 52) begin
      n = $urandom_range(8);
      send_byte(CHAR_QUOTE);
      repeat (n) send_byte(rand_other(CHAR_QUOTE));
      send_byte(CHAR_QUOTE);
    end else if (pick < 70) begin
      send_byte(op_chars[4'($urandom_range(9))]);
    end else if (pick < 82) begin
      n = $urandom_range(3, 1);
      repeat (n) send_byte(blank_chars[3'($urandom_range(5))]);
    end else if (pick < 90) begin
      // A comment closed by a newline, or now and then by end of input.
      n = $urandom_range(6);
      send_text("//");
      repeat (n) send_byte(rand_other(CHAR_NEWLINE));
      send_byte($urandom_range(3) == 0 ? CHAR_NUL : CHAR_NEWLINE);
    end else if (pick < 95) begin
      send_byte(CHAR_NUL);
    end else begin
      // A slash left pending, resolved by whatever comes next.
      send_byte(CHAR_SLASH);
    end
  endtask

  initial begin
    int n;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Every operator, tokens ended by other tokens, a pending slash resolved
    // both ways, back-to-back comments, a string with a high byte, and an
    // identifier ended by end of input.
    send_text("a=1;(){}+-*/9//c\n//\n\"");
    send_byte(8'hFF);
    send_text("\"b");
    send_byte(CHAR_NUL);

    // Random pieces, with a stretch in the middle where nobody idles.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      steady = sent >= 30 && sent < 100;
      send_piece();
    end
    steady = 1'b0;

    // An identifier long enough to saturate the length.
    n = $urandom_range(270, 256);
    send_byte(CHAR_SPACE);
    repeat (n) send_byte(rand_letter());
    send_byte(CHAR_SPACE);

    // End with one of the two errors; later bytes must give nothing.
    if ($urandom_range(1)) begin
      send_text("\"ab");
      send_byte(CHAR_NUL);
    end else begin
      send_byte($urandom_range(1) ? 8'h80 + 8'($urandom_range(127))
                                  : stray_chars[2'($urandom_range(3))]);
    end
    repeat (6) send_byte(8'($urandom_range(255)));
    in_valid_i = 1'b0;

    // Drain, then leave room for any stray beat to show up.
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
